>>> rtl/core/idct8_pkg.sv
// shared types, widths and kernel constants for the 8x8 inverse dct
// no dependencies; imported by the lane, merge and top modules of the block
package idct8_pkg;

    localparam int SAMP_W      = 16;
    localparam int KC_W        = 12;
    localparam int PROD_W      = 26;
    localparam int ACC_W       = 28;
    localparam int BFY_W       = 29;
    localparam int N_PT        = 8;
    localparam int IDX_W       = 3;
    localparam int ROUND_ADD   = 1024;
    localparam int SCALE_SHIFT = 11;

    typedef logic signed [SAMP_W-1:0] samp_t;
    typedef logic signed [KC_W-1:0]   kcoef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [BFY_W-1:0]  bfy_t;
    typedef logic [IDX_W-1:0]         idx_t;

    typedef samp_t  quad_t [4];
    typedef kcoef_t kern_row_t [4];
    typedef acc_t   acc_quad_t [4];
    typedef samp_t  row_t [N_PT];

    localparam idx_t IDX_LAST = idx_t'(N_PT - 1);

    localparam kern_row_t EVEN_K [4] = '{
        '{12'sd724,  12'sd946,  12'sd724,  12'sd392},
        '{12'sd724,  12'sd392, -12'sd724, -12'sd946},
        '{12'sd724, -12'sd392, -12'sd724,  12'sd946},
        '{12'sd724, -12'sd946,  12'sd724, -12'sd392}
    };

    localparam kern_row_t ODD_K [4] = '{
        '{ 12'sd1004,  12'sd851,   12'sd569,  12'sd200},
        '{-12'sd851,   12'sd200,   12'sd1004, 12'sd569},
        '{ 12'sd569,  -12'sd1004,  12'sd200,  12'sd851},
        '{-12'sd200,   12'sd569,  -12'sd851,  12'sd1004}
    };

    typedef struct packed {
        logic vld;
        logic col;
        idx_t idx;
    } tag_t;

    // round, floor shift, keep low 16 bits
    function automatic samp_t scale_down(bfy_t v);
        bfy_t t;
        t = v + bfy_t'(ROUND_ADD);
        return t[SCALE_SHIFT +: SAMP_W];
    endfunction

endpackage

>>> rtl/core/idct8_ram.sv
// generic single write port ram with registered read
// no dependencies; used for the transpose and output reorder banks
module idct8_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/idct8_lane.sv
// one kernel row lane: four constant products, then their sum, both registered
// depends on idct8_pkg
module idct8_lane
    import idct8_pkg::*;
(
    input  logic      clk,
    input  quad_t     x,
    input  kern_row_t kern,
    output acc_t      acc
);

    prod_t prod_reg  [4];
    prod_t prod_next [4];
    acc_t  acc_reg;
    acc_t  acc_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = prod_t'(x[i]) * prod_t'(kern[i]);
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc_next = acc_next + acc_t'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> rtl/core/idct8_merge.sv
// butterfly merge of even and odd lane sums, rounding and scaling, registered
// depends on idct8_pkg
module idct8_merge
    import idct8_pkg::*;
(
    input  logic      clk,
    input  acc_quad_t ge,
    input  acc_quad_t go,
    output row_t      y
);

    row_t y_reg;
    row_t y_next;

    always_comb
    begin
        bfy_t e;
        bfy_t o;
        for (int j = 0; j < 4; j++)
        begin
            e = bfy_t'(ge[j]);
            o = bfy_t'(go[j]);
            if ((j & 1) == 0)
            begin
                y_next[j]     = scale_down(e + o);
                y_next[7 - j] = scale_down(e - o);
            end
            else
            begin
                y_next[j]     = scale_down(e - o);
                y_next[7 - j] = scale_down(e + o);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

>>> rtl/core/idct_8x8_fixed_point.sv
// top level of the 8x8 fixed-point inverse dct: lanes, merge, banked stores, control
// depends on idct8_pkg, idct8_lane, idct8_merge, idct8_ram
//
// usage: present one row of eight coefficients on coef_0..coef_7 and raise start;
// the word is taken at a clock edge where start is high and busy is low. rows of a
// block go in order 0..7 and may follow one per cycle. each row runs through eight
// lanes (four even, four odd kernel rows, two register stages) and a butterfly merge
// stage, then lands skewed across eight transpose banks. after the eighth row busy
// rises: the row pipe drains, the eight columns are read back one per cycle through
// the same lanes, and column results fill eight output banks. the eight result rows
// then leave on pix_0..pix_7, one per cycle, each marked by a one-cycle strobe;
// last_row marks the eighth. with start held, block throughput is set by the single
// lane array shared by row and column passes, as no row is taken while busy; output
// of one block overlaps loading of the next. the receiver cannot stall.
// reset clears the row count and all control; the banks keep no reset value.
module idct_8x8_fixed_point
    import idct8_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  samp_t coef_0,
    input  samp_t coef_1,
    input  samp_t coef_2,
    input  samp_t coef_3,
    input  samp_t coef_4,
    input  samp_t coef_5,
    input  samp_t coef_6,
    input  samp_t coef_7,
    output logic  strobe,
    output samp_t pix_0,
    output samp_t pix_1,
    output samp_t pix_2,
    output samp_t pix_3,
    output samp_t pix_4,
    output samp_t pix_5,
    output samp_t pix_6,
    output samp_t pix_7,
    output logic  last_row
);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_DRAIN = 4'b0010,
        ST_COL   = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    idx_t   row_cnt_reg;
    idx_t   row_cnt_next;
    idx_t   col_cnt_reg;
    idx_t   col_cnt_next;
    logic   rd_vld_reg;
    logic   rd_vld_next;
    idx_t   rd_idx_reg;
    logic   out_act_reg;
    logic   out_act_next;
    idx_t   out_cnt_reg;
    idx_t   out_cnt_next;
    logic   o_vld_reg;
    idx_t   o_idx_reg;
    tag_t   tag0;
    tag_t   tag1_reg;
    tag_t   tag2_reg;
    tag_t   tag3_reg;

    logic      accept;
    logic      col_last_wr;
    logic      a_we;
    logic      b_we;
    row_t      x_in;
    quad_t     even_x;
    quad_t     odd_x;
    acc_quad_t ge;
    acc_quad_t go;
    row_t      y;
    row_t      wdata;
    row_t      a_rdata;
    row_t      b_rdata;
    row_t      pix_row;
    idx_t      a_raddr [N_PT];
    idx_t      b_raddr [N_PT];

    assign busy        = (state_reg != ST_LOAD);
    assign accept      = start && !busy;
    assign col_last_wr = tag3_reg.vld && tag3_reg.col && (tag3_reg.idx == IDX_LAST);

    // lane inputs: live row or rotated column read
    always_comb
    begin
        idx_t sel;
        for (int k = 0; k < N_PT; k++)
        begin
            sel     = idx_t'(k) + rd_idx_reg;
            x_in[k] = a_rdata[sel];
        end
        if (state_reg == ST_LOAD)
        begin
            x_in[0] = coef_0;
            x_in[1] = coef_1;
            x_in[2] = coef_2;
            x_in[3] = coef_3;
            x_in[4] = coef_4;
            x_in[5] = coef_5;
            x_in[6] = coef_6;
            x_in[7] = coef_7;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            even_x[i] = x_in[2 * i];
            odd_x[i]  = x_in[2 * i + 1];
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        idct8_lane u_even (
            .clk  (clk),
            .x    (even_x),
            .kern (EVEN_K[l]),
            .acc  (ge[l])
        );
        idct8_lane u_odd (
            .clk  (clk),
            .x    (odd_x),
            .kern (ODD_K[l]),
            .acc  (go[l])
        );
    end

    idct8_merge u_merge (
        .clk (clk),
        .ge  (ge),
        .go  (go),
        .y   (y)
    );

    // skewed bank placement: element k of word a lives in bank k+a at address a
    always_comb
    begin
        idx_t sel;
        for (int b = 0; b < N_PT; b++)
        begin
            sel        = idx_t'(b) - tag3_reg.idx;
            wdata[b]   = y[sel];
            a_raddr[b] = idx_t'(b) - col_cnt_reg;
            b_raddr[b] = idx_t'(b) - out_cnt_reg;
        end
    end

    assign a_we = tag3_reg.vld && !tag3_reg.col;
    assign b_we = tag3_reg.vld && tag3_reg.col;

    for (genvar b = 0; b < N_PT; b++)
    begin : g_bank
        idct8_ram #(
            .WIDTH (SAMP_W),
            .DEPTH (N_PT)
        ) u_tr (
            .clk   (clk),
            .we    (a_we),
            .waddr (tag3_reg.idx),
            .wdata (wdata[b]),
            .raddr (a_raddr[b]),
            .rdata (a_rdata[b])
        );
        idct8_ram #(
            .WIDTH (SAMP_W),
            .DEPTH (N_PT)
        ) u_out (
            .clk   (clk),
            .we    (b_we),
            .waddr (tag3_reg.idx),
            .wdata (wdata[b]),
            .raddr (b_raddr[b]),
            .rdata (b_rdata[b])
        );
    end

    always_comb
    begin
        tag0.vld = accept || rd_vld_reg;
        tag0.col = rd_vld_reg;
        tag0.idx = accept ? row_cnt_reg : rd_idx_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        rd_vld_next  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    row_cnt_next = row_cnt_reg + idx_t'(1);
                    if (row_cnt_reg == IDX_LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                col_cnt_next = '0;
                if (!(tag1_reg.vld || tag2_reg.vld || tag3_reg.vld))
                begin
                    state_next = ST_COL;
                end
            end
            ST_COL:
            begin
                rd_vld_next  = 1'b1;
                col_cnt_next = col_cnt_reg + idx_t'(1);
                if (col_cnt_reg == IDX_LAST)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (col_last_wr)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_act_next = out_act_reg;
        out_cnt_next = out_cnt_reg;
        if (col_last_wr)
        begin
            out_act_next = 1'b1;
            out_cnt_next = '0;
        end
        else if (out_act_reg)
        begin
            out_cnt_next = out_cnt_reg + idx_t'(1);
            if (out_cnt_reg == IDX_LAST)
            begin
                out_act_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            tag1_reg    <= '0;
            tag2_reg    <= '0;
            tag3_reg    <= '0;
            out_act_reg <= 1'b0;
            out_cnt_reg <= '0;
            o_vld_reg   <= 1'b0;
            o_idx_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            rd_vld_reg  <= rd_vld_next;
            rd_idx_reg  <= col_cnt_reg;
            tag1_reg    <= tag0;
            tag2_reg    <= tag1_reg;
            tag3_reg    <= tag2_reg;
            out_act_reg <= out_act_next;
            out_cnt_reg <= out_cnt_next;
            o_vld_reg   <= out_act_reg;
            o_idx_reg   <= out_cnt_reg;
        end
    end

    always_comb
    begin
        idx_t sel;
        for (int c = 0; c < N_PT; c++)
        begin
            sel        = idx_t'(c) + o_idx_reg;
            pix_row[c] = b_rdata[sel];
        end
    end

    assign strobe   = o_vld_reg;
    assign last_row = o_vld_reg && (o_idx_reg == IDX_LAST);
    assign pix_0    = pix_row[0];
    assign pix_1    = pix_row[1];
    assign pix_2    = pix_row[2];
    assign pix_3    = pix_row[3];
    assign pix_4    = pix_row[4];
    assign pix_5    = pix_row[5];
    assign pix_6    = pix_row[6];
    assign pix_7    = pix_row[7];

    a_no_row_write_during_col_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> !(tag3_reg.vld && !tag3_reg.col))
        else $error("row result written while column pass reads the transpose banks");

    a_out_banks_free: assert property (@(posedge clk) disable iff (!rst_n)
        (tag3_reg.vld && tag3_reg.col) |-> !out_act_reg)
        else $error("column result written while output banks are read");

    a_last_after_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_row |-> $past(strobe))
        else $error("last row word not preceded by a row word");

    a_busy_after_eighth: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_cnt_reg == IDX_LAST) |=> busy)
        else $error("eighth row taken without entering the column pass");

endmodule

>>> test/idct_8x8_fixed_point_test.sv
// self-checking testbench for the 8x8 fixed-point inverse dct: queued rows, random gaps,
// block-level prediction and per-field compare of every output row; depends on idct8_pkg
// and idct_8x8_fixed_point
`timescale 1ns / 1ps

module idct_8x8_fixed_point_test;
    import idct8_pkg::*;

    typedef logic [7:0][15:0] sample_row_t;

    typedef struct packed {
        sample_row_t coef;
        logic [5:0]  gap;
        logic        drain;
    } coef_word_t;

    typedef struct packed {
        sample_row_t pix;
        logic        last;
    } pix_word_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    samp_t coef_0 = '0;
    samp_t coef_1 = '0;
    samp_t coef_2 = '0;
    samp_t coef_3 = '0;
    samp_t coef_4 = '0;
    samp_t coef_5 = '0;
    samp_t coef_6 = '0;
    samp_t coef_7 = '0;
    logic  strobe;
    samp_t pix_0;
    samp_t pix_1;
    samp_t pix_2;
    samp_t pix_3;
    samp_t pix_4;
    samp_t pix_5;
    samp_t pix_6;
    samp_t pix_7;
    logic  last_row;

    coef_word_t  pending_rows [$];
    pix_word_t   expected_rows [$];
    logic [15:0] tile [64];
    logic [2:0]  rows_in;
    int          gap_left;
    int          errors = 0;

    idct_8x8_fixed_point u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .coef_0   (coef_0),
        .coef_1   (coef_1),
        .coef_2   (coef_2),
        .coef_3   (coef_3),
        .coef_4   (coef_4),
        .coef_5   (coef_5),
        .coef_6   (coef_6),
        .coef_7   (coef_7),
        .strobe   (strobe),
        .pix_0    (pix_0),
        .pix_1    (pix_1),
        .pix_2    (pix_2),
        .pix_3    (pix_3),
        .pix_4    (pix_4),
        .pix_5    (pix_5),
        .pix_6    (pix_6),
        .pix_7    (pix_7),
        .last_row (last_row)
    );

    always #6 clk = ~clk;

    // add 1024, floor shift by 11, keep low 16 bits
    function automatic logic [15:0] round_shift(longint v);
        longint t;
        t = (v + 64'sd1024) >>> 11;
        return t[15:0];
    endfunction

    function automatic sample_row_t idct_1d(sample_row_t x);
        longint x0, x1, x2, x3, x4, x5, x6, x7;
        longint e0, e1, e2, e3, o0, o1, o2, o3;
        sample_row_t y;
        x0 = $signed(x[0]);
        x1 = $signed(x[1]);
        x2 = $signed(x[2]);
        x3 = $signed(x[3]);
        x4 = $signed(x[4]);
        x5 = $signed(x[5]);
        x6 = $signed(x[6]);
        x7 = $signed(x[7]);
        e0 = 724 * x0 + 946 * x2 + 724 * x4 + 392 * x6;
        e1 = 724 * x0 + 392 * x2 - 724 * x4 - 946 * x6;
        e2 = 724 * x0 - 392 * x2 - 724 * x4 + 946 * x6;
        e3 = 724 * x0 - 946 * x2 + 724 * x4 - 392 * x6;
        o0 = 1004 * x1 + 851 * x3 + 569 * x5 + 200 * x7;
        o1 = -851 * x1 + 200 * x3 + 1004 * x5 + 569 * x7;
        o2 = 569 * x1 - 1004 * x3 + 200 * x5 + 851 * x7;
        o3 = -200 * x1 + 569 * x3 - 851 * x5 + 1004 * x7;
        y[0] = round_shift(e0 + o0);
        y[1] = round_shift(e1 - o1);
        y[2] = round_shift(e2 + o2);
        y[3] = round_shift(e3 - o3);
        y[4] = round_shift(e3 + o3);
        y[5] = round_shift(e2 - o2);
        y[6] = round_shift(e1 + o1);
        y[7] = round_shift(e0 - o0);
        return y;
    endfunction

    // row pass into the tile; on the eighth row run the column pass and queue eight rows
    task automatic load_row(sample_row_t c);
        sample_row_t y;
        sample_row_t col;
        sample_row_t pix [8];
        pix_word_t   w;
        y = idct_1d(c);
        for (int k = 0; k < 8; k++)
            tile[k * 8 + rows_in] = y[k];
        if (rows_in == 3'd7)
        begin
            for (int r = 0; r < 8; r++)
            begin
                for (int k = 0; k < 8; k++)
                    col[k] = tile[r * 8 + k];
                y = idct_1d(col);
                for (int k = 0; k < 8; k++)
                    pix[k][r] = y[k];
            end
            for (int k = 0; k < 8; k++)
            begin
                w.pix = pix[k];
                w.last = (k == 7);
                expected_rows.push_back(w);
            end
        end
        rows_in = rows_in + 3'd1;
    endtask

    task automatic queue_row(sample_row_t c, logic [5:0] gap, logic drain);
        coef_word_t w;
        w.coef = c;
        w.gap = gap;
        w.drain = drain;
        pending_rows.push_back(w);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        coef_word_t w;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
            rows_in = '0;
        end
        else
        begin
            if (start && !busy)
                load_row({coef_7, coef_6, coef_5, coef_4, coef_3, coef_2, coef_1, coef_0});
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_rows.size() != 0 &&
                         !(pending_rows[0].drain && expected_rows.size() != 0))
                begin
                    w = pending_rows.pop_front();
                    coef_0 <= w.coef[0];
                    coef_1 <= w.coef[1];
                    coef_2 <= w.coef[2];
                    coef_3 <= w.coef[3];
                    coef_4 <= w.coef[4];
                    coef_5 <= w.coef[5];
                    coef_6 <= w.coef[6];
                    coef_7 <= w.coef[7];
                    start <= 1'b1;
                    gap_left = int'(w.gap);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pix_word_t   w;
        sample_row_t got;
        if (rst_n && strobe)
        begin
            got = {pix_7, pix_6, pix_5, pix_4, pix_3, pix_2, pix_1, pix_0};
            if (expected_rows.size() == 0)
            begin
                $error("unexpected output word: pix_0 %0d last_row %0b", pix_0, last_row);
                errors++;
            end
            else
            begin
                w = expected_rows.pop_front();
                for (int k = 0; k < 8; k++)
                    if (got[k] !== w.pix[k])
                    begin
                        $error("pix_%0d expected %0d got %0d", k, $signed(w.pix[k]),
                               $signed(got[k]));
                        errors++;
                    end
                if (last_row !== w.last)
                begin
                    $error("last_row expected %0b got %0b", w.last, last_row);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        sample_row_t c;
        logic [15:0] v;
        int          mode;
        int          g;
        logic [5:0]  gap;
        bit          burst;

        // full-scale positive, full-scale negative, then a checkerboard of both
        for (int r = 0; r < 8; r++)
            queue_row({8{16'h7fff}}, 6'd0, 1'b0);
        for (int r = 0; r < 8; r++)
            queue_row({8{16'h8000}}, 6'($urandom_range(0, 3)), 1'b0);
        for (int r = 0; r < 8; r++)
        begin
            for (int k = 0; k < 8; k++)
                c[k] = ((r + k) % 2 == 0) ? 16'h7fff : 16'h8000;
            queue_row(c, 6'($urandom_range(0, 2)), r == 0);
        end

        for (int b = 0; b < 50; b++)
        begin
            mode = $urandom_range(0, 3);
            burst = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < 8; r++)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    case (mode)
                        0: v = 16'($urandom);
                        1: v = 16'($urandom_range(0, 511)) - 16'd256;
                        2: v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
                        default:
                            case ($urandom_range(0, 4))
                                0: v = 16'h7fff;
                                1: v = 16'h8000;
                                2: v = 16'h0000;
                                3: v = 16'hffff;
                                default: v = 16'h0001;
                            endcase
                    endcase
                    c[k] = v;
                end
                g = $urandom_range(0, 19);
                if (burst || g < 12)
                    gap = 6'd0;
                else if (g < 18)
                    gap = 6'($urandom_range(1, 3));
                else
                    gap = 6'($urandom_range(10, 40));
                queue_row(c, gap, r == 0 && b % 10 == 3);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // sample between edges so driver and monitor updates have settled
        while (pending_rows.size() != 0 || start)
            @(negedge clk);
        while (expected_rows.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0 && expected_rows.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
